// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the sensor reader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SWSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SWSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swsr_pkg.sv -----
// Package with types and constants of the single-wire sensor reader.
package swsr_pkg;

    localparam int PRE_HIGH_W  = 20;
    localparam int START_LOW_W = 16;
    localparam int REL_HIGH_W  = 8;
    localparam int THRESH_W    = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    localparam int CNT_W       = 20;
    localparam int PW_W        = 8;
    localparam int BITS_W      = 6;
    localparam int NUM_BITS    = 40;
    localparam logic [PW_W-1:0] PW_MAX = 8'd255;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRE_HIGH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REL_HIGH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [PRE_HIGH_W-1:0]  PRE_HIGH_RST  = 20'd100000;
    localparam logic [START_LOW_W-1:0] START_LOW_RST = 16'd100;
    localparam logic [REL_HIGH_W-1:0]  REL_HIGH_RST  = 8'd4;
    localparam logic [THRESH_W-1:0]    THRESH_RST    = 8'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_HUM_ZERO = 2'd2;

    typedef struct packed {
        logic [PRE_HIGH_W-1:0]  pre_high_ticks;
        logic [START_LOW_W-1:0] start_low_ticks;
        logic [REL_HIGH_W-1:0]  release_high_ticks;
        logic [THRESH_W-1:0]    one_threshold;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temperature_raw;
        logic [15:0] humidity_raw;
        logic        result_valid;
        logic        busy_res;
        logic        drive_level;
        logic        drive_enable;
    } t_result;

endpackage

// ----- rtl/swsr_cfg_regs.sv -----
// Configuration register file of the single-wire sensor reader.
module swsr_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output swsr_pkg::t_cfg                     o_cfg
);

    swsr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_high_ticks     <= swsr_pkg::PRE_HIGH_RST;
            r_cfg.start_low_ticks    <= swsr_pkg::START_LOW_RST;
            r_cfg.release_high_ticks <= swsr_pkg::REL_HIGH_RST;
            r_cfg.one_threshold      <= swsr_pkg::THRESH_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                swsr_pkg::CFG_PRE_HIGH: begin
                    r_cfg.pre_high_ticks <= i_cfg_wdata[swsr_pkg::PRE_HIGH_W-1:0];
                end
                swsr_pkg::CFG_START_LOW: begin
                    r_cfg.start_low_ticks <= i_cfg_wdata[swsr_pkg::START_LOW_W-1:0];
                end
                swsr_pkg::CFG_REL_HIGH: begin
                    r_cfg.release_high_ticks <= i_cfg_wdata[swsr_pkg::REL_HIGH_W-1:0];
                end
                default: begin
                    r_cfg.one_threshold <= i_cfg_wdata[swsr_pkg::THRESH_W-1:0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/swsr_core.sv -----
// Read sequencer: start pulse, response wait, bit timing and result decode.
module swsr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_start_request,
    input  logic                i_line_level,
    input  swsr_pkg::t_cfg      i_cfg,
    output swsr_pkg::t_result   o_result
);

    localparam logic [3:0] PH_IDLE        = 4'd0;
    localparam logic [3:0] PH_PRE_HIGH    = 4'd1;
    localparam logic [3:0] PH_START_LOW   = 4'd2;
    localparam logic [3:0] PH_REL_HIGH    = 4'd3;
    localparam logic [3:0] PH_RESP_LOW1   = 4'd4;
    localparam logic [3:0] PH_RESP_HIGH   = 4'd5;
    localparam logic [3:0] PH_RESP_LOW2   = 4'd6;
    localparam logic [3:0] PH_BIT_WAIT    = 4'd7;
    localparam logic [3:0] PH_BIT_MEASURE = 4'd8;

    localparam int CNT_W  = swsr_pkg::CNT_W;
    localparam int PW_W   = swsr_pkg::PW_W;
    localparam int BITS_W = swsr_pkg::BITS_W;
    localparam int NB     = swsr_pkg::NUM_BITS;

    logic [3:0]        r_phase,  n_phase;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic [PW_W-1:0]   r_pw,     n_pw;
    logic [BITS_W-1:0] r_bits,   n_bits;
    logic [NB-1:0]     r_rb,     n_rb;

    logic [3:0]        ph_eff;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  limit;
    logic [PW_W-1:0]   pw_eff;
    logic [BITS_W-1:0] bits_eff;
    logic [BITS_W-1:0] bits_new;
    logic [NB-1:0]     rb_eff;
    logic [NB-1:0]     rb_new;
    logic              bit_val;
    logic [9:0]        sum_full;
    logic [7:0]        b0, b1, b2, b3, b4;
    swsr_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_pw    <= '0;
            r_bits  <= '0;
            r_rb    <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_pw    <= n_pw;
            r_bits  <= n_bits;
            r_rb    <= n_rb;
        end
    end

    // The tick that starts a read is already the first pre-high tick.
    always_comb begin
        if (r_phase == PH_IDLE && i_start_request) begin
            ph_eff   = PH_PRE_HIGH;
            cnt_eff  = '0;
            pw_eff   = '0;
            bits_eff = '0;
            rb_eff   = '0;
        end else begin
            ph_eff   = r_phase;
            cnt_eff  = r_cnt;
            pw_eff   = r_pw;
            bits_eff = r_bits;
            rb_eff   = r_rb;
        end
    end

    assign cnt_inc  = cnt_eff + CNT_W'(1);
    assign bit_val  = (pw_eff > i_cfg.one_threshold);
    assign rb_new   = {rb_eff[NB-2:0], bit_val};
    assign bits_new = bits_eff + BITS_W'(1);
    assign b0       = rb_new[39:32];
    assign b1       = rb_new[31:24];
    assign b2       = rb_new[23:16];
    assign b3       = rb_new[15:8];
    assign b4       = rb_new[7:0];
    assign sum_full = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};

    always_comb begin
        case (ph_eff)
            PH_PRE_HIGH:  limit = i_cfg.pre_high_ticks;
            PH_START_LOW: limit = {{(CNT_W-swsr_pkg::START_LOW_W){1'b0}},
                                   i_cfg.start_low_ticks};
            default:      limit = {{(CNT_W-swsr_pkg::REL_HIGH_W){1'b0}},
                                   i_cfg.release_high_ticks};
        endcase
    end

    always_comb begin
        n_phase = ph_eff;
        n_cnt   = cnt_eff;
        n_pw    = pw_eff;
        n_bits  = bits_eff;
        n_rb    = rb_eff;
        res     = '0;

        unique case (ph_eff) inside
            PH_PRE_HIGH, PH_START_LOW, PH_REL_HIGH: begin
                res.drive_enable = 1'b1;
                res.drive_level  = (ph_eff != PH_START_LOW);
                if (cnt_inc >= limit) begin
                    n_cnt = '0;
                    if (ph_eff == PH_PRE_HIGH) begin
                        n_phase = PH_START_LOW;
                    end else if (ph_eff == PH_START_LOW) begin
                        n_phase = PH_REL_HIGH;
                    end else begin
                        n_phase = PH_RESP_LOW1;
                    end
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_RESP_LOW1: begin
                if (!i_line_level) n_phase = PH_RESP_HIGH;
            end
            PH_RESP_HIGH: begin
                if (i_line_level) n_phase = PH_RESP_LOW2;
            end
            PH_RESP_LOW2: begin
                if (!i_line_level) n_phase = PH_BIT_WAIT;
            end
            PH_BIT_WAIT: begin
                if (i_line_level) begin
                    n_phase = PH_BIT_MEASURE;
                    n_pw    = PW_W'(1);
                end
            end
            PH_BIT_MEASURE: begin
                if (i_line_level) begin
                    if (pw_eff != swsr_pkg::PW_MAX) n_pw = pw_eff + PW_W'(1);
                end else begin
                    n_rb = rb_new;
                    n_pw = '0;
                    if (bits_new >= BITS_W'(NB)) begin
                        res.result_valid    = 1'b1;
                        res.humidity_raw    = {b0, b1};
                        res.temperature_raw = {b2, b3};
                        // A checksum mismatch wins over a zero humidity byte.
                        if (sum_full[7:0] != b4) begin
                            res.status = swsr_pkg::STATUS_CHECKSUM;
                        end else if (b0 == 8'd0) begin
                            res.status = swsr_pkg::STATUS_HUM_ZERO;
                        end else begin
                            res.status = swsr_pkg::STATUS_OK;
                        end
                        n_phase = PH_IDLE;
                        n_bits  = '0;
                    end else begin
                        n_bits  = bits_new;
                        n_phase = PH_BIT_WAIT;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        res.busy_res = (n_phase != PH_IDLE);
    end

    assign o_result = res;

endmodule

// ----- rtl/single_wire_sensor_reader.sv -----
// Top level of the single-wire sensor reader: stream ports, staging registers.
// A request is registered in the input stage, then its result in the output stage.
// Throughput: one request per cycle while the output side is ready.
// The input and output stages stall only when the output side is not ready.
// Reset (i_rst_n low, synchronous) empties both stages, idles the sequencer
// and loads the configuration registers with their default values.
module single_wire_sensor_reader (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: [0] start_request, [1] line_level, [7:2] zero
    input  logic [swsr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: [0] drive_enable, [1] drive_level, [2] busy_res, [3] result_valid,
    // [19:4] humidity_raw, [35:20] temperature_raw, [37:36] status, [39:38] zero
    output logic [swsr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  i_cfg_wr_en,
    input  logic [swsr_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [swsr_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    swsr_pkg::t_cfg    cfg;
    swsr_pkg::t_result result;

    logic       r_in_valid;
    logic       r_in_start;
    logic       r_in_line;
    logic       r_out_valid;
    logic [$bits(swsr_pkg::t_result)-1:0] r_out_data;
    logic       advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_start <= s_axis_tdata[0];
            r_in_line  <= s_axis_tdata[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    swsr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    swsr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_start_request (r_in_start),
        .i_line_level    (r_in_line),
        .i_cfg           (cfg),
        .o_result        (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(swsr_pkg::OUT_TDATA_W - $bits(swsr_pkg::t_result)){1'b0}},
                            r_out_data};

endmodule

// ----- rtl/swsr_checker.sv -----
// Port-level checker of the single-wire sensor reader, bound to the top level.
`include "assert_macros.svh"

module swsr_port_asserts (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [swsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // A stalled result must hold.
    `SWSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // The finishing tick leaves the block idle.
    `SWSR_ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3], !m_axis_tdata[2], "busy on finishing tick")

    // The drive level is never set while the line is released (drive enable low).
    `SWSR_ASSERT_IMPL(a_level_needs_enable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], !m_axis_tdata[1], "level set while released")

    // Read data and status are zero except on the finishing tick.
    `SWSR_ASSERT_IMPL(a_payload_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[3], m_axis_tdata[39:4] == 36'd0, "payload without result")

endmodule

bind single_wire_sensor_reader swsr_port_asserts u_swsr_asserts (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
